// ===== src/ps2kmc_pkg.sv =====
package ps2kmc_pkg;

	typedef enum logic [2:0] {
		KIND_CMD_WRITE  = 3'd0,
		KIND_DATA_WRITE = 3'd1,
		KIND_DATA_READ  = 3'd2,
		KIND_STAT_READ  = 3'd3,
		KIND_KBD_SET    = 3'd4,
		KIND_KBD_CLR    = 3'd5,
		KIND_MOUSE_SET  = 3'd6,
		KIND_MOUSE_CLR  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_MODE  = 2'd1,
		TGT_MOUSE = 2'd2
	} tgt_t;

	typedef enum logic [1:0] {
		FWD_NONE  = 2'd0,
		FWD_KBD   = 2'd1,
		FWD_MOUSE = 2'd2
	} fwd_t;

	localparam logic [7:0] CMD_READ_MODE     = 8'h20;
	localparam logic [7:0] CMD_WRITE_MODE    = 8'h60;
	localparam logic [7:0] CMD_MOUSE_OFF     = 8'ha7;
	localparam logic [7:0] CMD_MOUSE_ON      = 8'ha8;
	localparam logic [7:0] CMD_SELF_TEST     = 8'haa;
	localparam logic [7:0] CMD_KBD_OFF       = 8'had;
	localparam logic [7:0] CMD_KBD_ON        = 8'hae;
	localparam logic [7:0] CMD_WRITE_MOUSE   = 8'hd4;

	localparam logic [7:0] SELF_TEST_OK      = 8'h55;
	localparam logic [7:0] STATUS_RESET      = 8'h08;
	localparam logic [7:0] MODE_RESET        = 8'h03;
	localparam logic [7:0] MODE_KBD_MASK     = 8'h10;
	localparam logic [7:0] MODE_MOUSE_MASK   = 8'h20;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
		logic [7:0] keyboard_byte;
		logic [7:0] mouse_byte;
	} req_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       kbd_interrupt;
		logic       mouse_interrupt;
		logic [1:0] forward_kind;
		logic [7:0] forward_byte;
		logic       took_keyboard_byte;
		logic       took_mouse_byte;
		logic       fault;
	} rsp_word_t;

endpackage

// ===== src/ps2kmc_if.sv =====
interface ps2kmc_req_if
	import ps2kmc_pkg::*;
	();
	logic      valid;
	logic      ready;
	req_word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface ps2kmc_rsp_if
	import ps2kmc_pkg::*;
	();
	logic      valid;
	logic      ready;
	rsp_word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== src/ps2_keyboard_mouse_controller_top.sv =====
// An accepted request word is held in the input register, its response
// word in the response register. Throughput: one word per cycle while
// rsp.ready holds; controller state updates in one pass between them.
// Reset: asynchronous, active low; mode 0x03, status 0x08, output buffer,
// pending flags and pending command target cleared, both pipeline stages empty.
module ps2_keyboard_mouse_controller_top
	import ps2kmc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ps2kmc_req_if.sink   req,
	ps2kmc_rsp_if.source rsp
);

	logic      valid_s1;
	req_word_t word_s1;
	logic      valid_s2;
	rsp_word_t word_s2;

	tgt_t       target_q;
	logic       full_q;
	logic [7:0] obuf_q;
	logic [7:0] mode_q;
	logic       kbd_pend_q;
	logic       mouse_pend_q;

	tgt_t       target_d;
	logic       full_d;
	logic [7:0] obuf_d;
	logic [7:0] mode_d;
	logic       kbd_pend_d;
	logic       mouse_pend_d;
	rsp_word_t  rsp_d;

	logic advance;
	logic fire;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	assign rsp.valid = valid_s2;
	assign rsp.word  = word_s2;

	always_comb begin
		target_d     = target_q;
		full_d       = full_q;
		obuf_d       = obuf_q;
		mode_d       = mode_q;
		kbd_pend_d   = kbd_pend_q;
		mouse_pend_d = mouse_pend_q;
		rsp_d        = '0;
		case (kind_t'(word_s1.cmd))
			KIND_CMD_WRITE: begin
				case (word_s1.value)
					CMD_READ_MODE: begin
						obuf_d = mode_q;
						full_d = 1'b1;
					end
					CMD_WRITE_MODE:  target_d = TGT_MODE;
					CMD_MOUSE_OFF:   mode_d = mode_q | MODE_MOUSE_MASK;
					CMD_MOUSE_ON:    mode_d = mode_q & ~MODE_MOUSE_MASK;
					CMD_SELF_TEST: begin
						obuf_d = SELF_TEST_OK;
						full_d = 1'b1;
					end
					CMD_KBD_OFF:     mode_d = mode_q | MODE_KBD_MASK;
					CMD_KBD_ON:      mode_d = mode_q & ~MODE_KBD_MASK;
					CMD_WRITE_MOUSE: target_d = TGT_MOUSE;
					default:         rsp_d.fault = 1'b1;
				endcase
			end
			KIND_DATA_WRITE: begin
				case (target_q)
					TGT_MODE: mode_d = word_s1.value;
					TGT_MOUSE: begin
						rsp_d.forward_kind = FWD_MOUSE;
						rsp_d.forward_byte = word_s1.value;
					end
					default: begin
						rsp_d.forward_kind = FWD_KBD;
						rsp_d.forward_byte = word_s1.value;
					end
				endcase
				target_d = TGT_NONE;
			end
			KIND_DATA_READ: begin
				if (kbd_pend_q) begin
					rsp_d.read_data          = word_s1.keyboard_byte;
					rsp_d.took_keyboard_byte = 1'b1;
					kbd_pend_d               = 1'b0;
				end else if (mouse_pend_q) begin
					rsp_d.read_data       = word_s1.mouse_byte;
					rsp_d.took_mouse_byte = 1'b1;
					mouse_pend_d          = 1'b0;
				end else begin
					rsp_d.read_data = obuf_q;
					full_d          = 1'b0;
				end
			end
			KIND_STAT_READ: rsp_d.read_data = {STATUS_RESET[7:1], full_q};
			KIND_KBD_SET:   kbd_pend_d = 1'b1;
			KIND_KBD_CLR:   kbd_pend_d = 1'b0;
			KIND_MOUSE_SET: mouse_pend_d = 1'b1;
			default:        mouse_pend_d = 1'b0;
		endcase
		rsp_d.kbd_interrupt   = kbd_pend_d && ((mode_d & MODE_KBD_MASK) == '0);
		rsp_d.mouse_interrupt = !rsp_d.kbd_interrupt && mouse_pend_d
			&& ((mode_d & MODE_MOUSE_MASK) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			word_s1 <= req.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			target_q     <= TGT_NONE;
			full_q       <= STATUS_RESET[0];
			obuf_q       <= '0;
			mode_q       <= MODE_RESET;
			kbd_pend_q   <= 1'b0;
			mouse_pend_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				target_q     <= target_d;
				full_q       <= full_d;
				obuf_q       <= obuf_d;
				mode_q       <= mode_d;
				kbd_pend_q   <= kbd_pend_d;
				mouse_pend_q <= mouse_pend_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			word_s2 <= rsp_d;
		end
	end

	a_irq_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(word_s2.kbd_interrupt && word_s2.mouse_interrupt))
		else $error("both interrupt lines raised");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && word_s2.fault) |-> (word_s2.read_data == '0
			&& word_s2.forward_kind == FWD_NONE))
		else $error("faulting word carries data");

	a_fault_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rsp_d.fault) |=> ($stable(mode_q) && $stable(obuf_q)
			&& $stable(full_q) && $stable(target_q)))
		else $error("unsupported command changed state");

	a_self_test_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && word_s1.cmd == KIND_CMD_WRITE && word_s1.value == CMD_SELF_TEST)
			|=> (full_q && obuf_q == SELF_TEST_OK))
		else $error("self test did not load output buffer");

	a_single_take: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(word_s2.took_keyboard_byte && word_s2.took_mouse_byte))
		else $error("data read took both device bytes");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ps2kmc_pkg::*;

	localparam int N_DIR = 29;
	localparam int N_RAND = 1600;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_LINES = 40;
	localparam logic [7:0] STATUS_FULL = 8'h01;

	typedef struct packed {
		req_word_t w;
		logic      typed;
		rsp_word_t r;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ps2kmc_req_if req_ch ();
	ps2kmc_rsp_if rsp_ch ();

	ps2_keyboard_mouse_controller_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tgt_t       ctl_target;
	logic [7:0] ctl_status;
	logic [7:0] ctl_obuf;
	logic [7:0] ctl_mode;
	logic       ctl_kbd_pend;
	logic       ctl_mouse_pend;

	rsp_word_t due_rsp [$];
	dir_row_t  dir_tab [N_DIR];
	int        sent;
	int        errors;
	int        stall_cycles;
	bit        no_idle;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rsp_word_t apply_access(input req_word_t w);
		rsp_word_t r;
		r = '0;
		case (kind_t'(w.cmd))
		KIND_CMD_WRITE: begin
			case (w.value)
			CMD_READ_MODE: begin
				ctl_obuf = ctl_mode;
				ctl_status = ctl_status | STATUS_FULL;
			end
			CMD_WRITE_MODE: ctl_target = TGT_MODE;
			CMD_MOUSE_OFF: ctl_mode = ctl_mode | MODE_MOUSE_MASK;
			CMD_MOUSE_ON: ctl_mode = ctl_mode & ~MODE_MOUSE_MASK;
			CMD_SELF_TEST: begin
				ctl_obuf = SELF_TEST_OK;
				ctl_status = ctl_status | STATUS_FULL;
			end
			CMD_KBD_OFF: ctl_mode = ctl_mode | MODE_KBD_MASK;
			CMD_KBD_ON: ctl_mode = ctl_mode & ~MODE_KBD_MASK;
			CMD_WRITE_MOUSE: ctl_target = TGT_MOUSE;
			default: r.fault = 1'b1;
			endcase
		end
		KIND_DATA_WRITE: begin
			if (ctl_target == TGT_MODE) begin
				ctl_mode = w.value;
			end else begin
				r.forward_kind = (ctl_target == TGT_MOUSE) ? FWD_MOUSE : FWD_KBD;
				r.forward_byte = w.value;
			end
			ctl_target = TGT_NONE;
		end
		KIND_DATA_READ: begin
			if (ctl_kbd_pend) begin
				r.read_data = w.keyboard_byte;
				r.took_keyboard_byte = 1'b1;
				ctl_kbd_pend = 1'b0;
			end else if (ctl_mouse_pend) begin
				r.read_data = w.mouse_byte;
				r.took_mouse_byte = 1'b1;
				ctl_mouse_pend = 1'b0;
			end else begin
				r.read_data = ctl_obuf;
				ctl_status = ctl_status & ~STATUS_FULL;
			end
		end
		KIND_STAT_READ: r.read_data = ctl_status;
		KIND_KBD_SET: ctl_kbd_pend = 1'b1;
		KIND_KBD_CLR: ctl_kbd_pend = 1'b0;
		KIND_MOUSE_SET: ctl_mouse_pend = 1'b1;
		default: ctl_mouse_pend = 1'b0;
		endcase
		r.kbd_interrupt = ctl_kbd_pend && ((ctl_mode & MODE_KBD_MASK) == 8'h00);
		r.mouse_interrupt = !r.kbd_interrupt && ctl_mouse_pend &&
			((ctl_mode & MODE_MOUSE_MASK) == 8'h00);
		return r;
	endfunction

	function automatic logic [7:0] any_cmd();
		case ($urandom_range(7))
		0: return CMD_READ_MODE;
		1: return CMD_WRITE_MODE;
		2: return CMD_MOUSE_OFF;
		3: return CMD_MOUSE_ON;
		4: return CMD_SELF_TEST;
		5: return CMD_KBD_OFF;
		6: return CMD_KBD_ON;
		default: return CMD_WRITE_MOUSE;
		endcase
	endfunction

	task automatic log_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		errors++;
		if (errors <= MAX_LINES)
			$display("%0t: %0s got %h want %h", $time, what, got, want);
	endtask

	task automatic send_access(input req_word_t w, input logic typed, input rsp_word_t want);
		rsp_word_t p;
		while (!no_idle && $urandom_range(99) < 27) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		p = apply_access(w);
		req_ch.valid <= 1'b1;
		req_ch.word <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		due_rsp.push_back(typed ? want : p);
		sent++;
	endtask

	task automatic issue(input kind_t k, input logic [7:0] v);
		req_word_t w;
		w.cmd = k;
		w.value = v;
		w.keyboard_byte = 8'($urandom_range(255));
		w.mouse_byte = 8'($urandom_range(255));
		send_access(w, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= no_idle || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin : rsp_check
		rsp_word_t got;
		rsp_word_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.word;
			if (due_rsp.size() == 0) begin
				log_mismatch("unexpected word, read_data", got.read_data, 8'h00);
			end else begin
				want = due_rsp.pop_front();
				if (got.read_data !== want.read_data)
					log_mismatch("read_data", got.read_data, want.read_data);
				if (got.kbd_interrupt !== want.kbd_interrupt)
					log_mismatch("kbd_interrupt", 8'(got.kbd_interrupt),
						8'(want.kbd_interrupt));
				if (got.mouse_interrupt !== want.mouse_interrupt)
					log_mismatch("mouse_interrupt", 8'(got.mouse_interrupt),
						8'(want.mouse_interrupt));
				if (got.forward_kind !== want.forward_kind)
					log_mismatch("forward_kind", 8'(got.forward_kind),
						8'(want.forward_kind));
				if (got.forward_byte !== want.forward_byte)
					log_mismatch("forward_byte", got.forward_byte, want.forward_byte);
				if (got.took_keyboard_byte !== want.took_keyboard_byte)
					log_mismatch("took_keyboard_byte", 8'(got.took_keyboard_byte),
						8'(want.took_keyboard_byte));
				if (got.took_mouse_byte !== want.took_mouse_byte)
					log_mismatch("took_mouse_byte", 8'(got.took_mouse_byte),
						8'(want.took_mouse_byte));
				if (got.fault !== want.fault)
					log_mismatch("fault", 8'(got.fault), 8'(want.fault));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL ps2_keyboard_mouse_controller_top");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int pick;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.word = '0;
		rsp_ch.ready = 1'b0;
		sent = 0;
		errors = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		ctl_target = TGT_NONE;
		ctl_status = STATUS_RESET;
		ctl_obuf = 8'h00;
		ctl_mode = MODE_RESET;
		ctl_kbd_pend = 1'b0;
		ctl_mouse_pend = 1'b0;

		dir_tab = '{
			{KIND_STAT_READ, 8'h00, 8'h00, 8'h00, 1'b1, 8'h08, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_DATA_READ, 8'h00, 8'hff, 8'hff, 1'b1, 8'h00, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_CMD_WRITE, CMD_READ_MODE, 8'h00, 8'h00, 1'b1,
				8'h00, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_DATA_READ, 8'h00, 8'h00, 8'h00, 1'b1, 8'h03, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_CMD_WRITE, CMD_SELF_TEST, 8'h00, 8'h00, 1'b1,
				8'h00, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_STAT_READ, 8'h00, 8'h00, 8'h00, 1'b1, 8'h09, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_DATA_READ, 8'h00, 8'h00, 8'h00, 1'b1, 8'h55, 2'b00, FWD_NONE, 8'h00, 3'b000},
			{KIND_CMD_WRITE, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 2'b00, FWD_NONE, 8'h00, 3'b001},
			{KIND_CMD_WRITE, 8'hff, 8'h00, 8'h00, 1'b1, 8'h00, 2'b00, FWD_NONE, 8'h00, 3'b001},
			{KIND_KBD_SET, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 2'b10, FWD_NONE, 8'h00, 3'b000},
			{KIND_MOUSE_SET, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 2'b10, FWD_NONE, 8'h00, 3'b000},
			{KIND_DATA_READ, 8'h00, 8'hff, 8'h00, 1'b1, 8'hff, 2'b01, FWD_NONE, 8'h00, 3'b100},
			{KIND_DATA_READ, 8'h00, 8'h00, 8'ha5, 1'b1, 8'ha5, 2'b00, FWD_NONE, 8'h00, 3'b010},
			{KIND_DATA_WRITE, 8'hff, 8'h00, 8'h00, 1'b1, 8'h00, 2'b00, FWD_KBD, 8'hff, 3'b000},
			{KIND_CMD_WRITE, CMD_WRITE_MOUSE, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_MOUSE_OFF, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_DATA_WRITE, 8'h00, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_WRITE_MODE, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_WRITE_MOUSE, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_DATA_WRITE, 8'h5a, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_WRITE_MODE, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_DATA_WRITE, 8'hff, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_KBD_SET, 8'h00, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_MOUSE_SET, 8'h00, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_KBD_ON, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_KBD_CLR, 8'h00, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_MOUSE_ON, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_MOUSE_CLR, 8'h00, 8'h00, 8'h00, 1'b0, 23'h0},
			{KIND_CMD_WRITE, CMD_KBD_OFF, 8'h00, 8'h00, 1'b0, 23'h0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_access(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);

		while (sent < N_DIR + N_RAND) begin
			no_idle = (sent >= 700 && sent < 1000);
			pick = $urandom_range(99);
			if (pick < 14) begin
				issue(KIND_CMD_WRITE, CMD_WRITE_MODE);
				if ($urandom_range(3) == 0)
					issue(KIND_CMD_WRITE, any_cmd());
				issue(KIND_DATA_WRITE, 8'($urandom_range(255)));
			end else if (pick < 26) begin
				issue(KIND_CMD_WRITE, CMD_WRITE_MOUSE);
				if ($urandom_range(3) == 0)
					issue(KIND_CMD_WRITE, any_cmd());
				issue(KIND_DATA_WRITE, 8'($urandom_range(255)));
			end else if (pick < 44) begin
				repeat ($urandom_range(1, 3))
					issue(kind_t'(3'($urandom_range(7, 4))), 8'($urandom_range(255)));
				repeat ($urandom_range(1, 3))
					issue(KIND_DATA_READ, 8'($urandom_range(255)));
			end else if (pick < 54) begin
				issue(KIND_CMD_WRITE, $urandom_range(1) ? CMD_READ_MODE : CMD_SELF_TEST);
				issue(KIND_STAT_READ, 8'($urandom_range(255)));
				issue(KIND_DATA_READ, 8'($urandom_range(255)));
			end else if (pick < 70) begin
				issue(KIND_CMD_WRITE, any_cmd());
			end else if (pick < 82) begin
				issue($urandom_range(1) ? KIND_DATA_READ : KIND_STAT_READ,
					8'($urandom_range(255)));
			end else if (pick < 90) begin
				issue(KIND_DATA_WRITE, 8'($urandom_range(255)));
			end else begin
				issue(kind_t'(3'($urandom_range(7))), 8'($urandom_range(255)));
			end
		end
		no_idle = 1'b0;

		req_ch.valid <= 1'b0;
		while (due_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("PASS ps2_keyboard_mouse_controller_top");
		end else begin
			$display("FAIL ps2_keyboard_mouse_controller_top");
		end
		$finish;
	end

endmodule
